// ----- hw/rtl/tape_block_pulse_generator_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the tape block pulse generator
// Shorthand for concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TAPE_BLOCK_PULSE_GENERATOR_ASSERT_SVH
`define TAPE_BLOCK_PULSE_GENERATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define TBPG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define TBPG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tbpg_pkg.sv -----
// ---------------------------------------------------------------------------
// Tape block pulse generator package
// Transaction types, register bank layout, codes and timing constants.
// ---------------------------------------------------------------------------
package tbpg_pkg;

    localparam int CYCLE_BITS = 32;
    localparam int GAP_LIMIT  = 50000;

    localparam int LEN_BITS   = 12;
    localparam int COUNT_BITS = 14;
    localparam int PAUSE_BITS = 24;
    localparam int OFFS_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CYCLE_BITS-1:0] GAP_LIMIT_CYC = CYCLE_BITS'(GAP_LIMIT);
    localparam logic [7:0]            BIT_SEL_MSB   = 8'h80;

    // Register reset values
    localparam logic [LEN_BITS-1:0]   PILOT_HALF_RST  = 12'd2168;
    localparam logic [LEN_BITS-1:0]   SYNC_FIRST_RST  = 12'd667;
    localparam logic [LEN_BITS-1:0]   SYNC_SECOND_RST = 12'd735;
    localparam logic [LEN_BITS-1:0]   ZERO_HALF_RST   = 12'd855;
    localparam logic [LEN_BITS-1:0]   ONE_HALF_RST    = 12'd1710;
    localparam logic [COUNT_BITS-1:0] HDR_PILOT_RST   = 14'd8063;
    localparam logic [COUNT_BITS-1:0] DATA_PILOT_RST  = 14'd3223;
    localparam logic [PAUSE_BITS-1:0] PAUSE_RST       = 24'd3500000;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_START  = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        PLAY_STOPPED = 2'd0,
        PLAY_RUNNING = 2'd1,
        PLAY_PAUSED  = 2'd2
    } play_e_t;

    typedef enum logic [2:0] {
        PH_PILOT = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_DATA  = 3'd3,
        PH_PAUSE = 3'd4
    } phase_e_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PILOT_HALF  = 3'd0,
        CFG_SYNC_FIRST  = 3'd1,
        CFG_SYNC_SECOND = 3'd2,
        CFG_ZERO_HALF   = 3'd3,
        CFG_ONE_HALF    = 3'd4,
        CFG_HDR_PILOT   = 3'd5,
        CFG_DATA_PILOT  = 3'd6,
        CFG_PAUSE       = 3'd7
    } cfg_idx_e_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [CYCLE_BITS-1:0] cycle_now;
        logic [7:0]            cur_byte;
        logic [7:0]            next_byte;
        logic [OFFS_BITS-1:0]  block_size;
        logic                  block_is_data;
        logic                  last_block;
    } in_item_t;

    typedef struct packed {
        logic                 ear_level;
        logic [1:0]           play_status;
        logic [2:0]           signal_phase;
        logic [OFFS_BITS-1:0] byte_offset;
        logic                 block_request;
        logic                 tape_end;
    } out_item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]   pilot_half_len;
        logic [LEN_BITS-1:0]   sync_first_len;
        logic [LEN_BITS-1:0]   sync_second_len;
        logic [LEN_BITS-1:0]   zero_half_len;
        logic [LEN_BITS-1:0]   one_half_len;
        logic [COUNT_BITS-1:0] header_pilot_count;
        logic [COUNT_BITS-1:0] data_pilot_count;
        logic [PAUSE_BITS-1:0] pause_len;
    } cfg_t;

endpackage

// ----- hw/rtl/tbpg_cfg.sv -----
// ---------------------------------------------------------------------------
// Tape block pulse generator register bank
// Holds the timing registers and takes one write transaction per cycle.
// ---------------------------------------------------------------------------
module tbpg_cfg
    import tbpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the write data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_e_t'(wr_index))
                CFG_PILOT_HALF:  cfg_next.pilot_half_len     = wr_data[LEN_BITS-1:0];
                CFG_SYNC_FIRST:  cfg_next.sync_first_len     = wr_data[LEN_BITS-1:0];
                CFG_SYNC_SECOND: cfg_next.sync_second_len    = wr_data[LEN_BITS-1:0];
                CFG_ZERO_HALF:   cfg_next.zero_half_len      = wr_data[LEN_BITS-1:0];
                CFG_ONE_HALF:    cfg_next.one_half_len       = wr_data[LEN_BITS-1:0];
                CFG_HDR_PILOT:   cfg_next.header_pilot_count = wr_data[COUNT_BITS-1:0];
                CFG_DATA_PILOT:  cfg_next.data_pilot_count   = wr_data[COUNT_BITS-1:0];
                CFG_PAUSE:       cfg_next.pause_len          = wr_data[PAUSE_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pilot_half_len     <= PILOT_HALF_RST;
            cfg_reg.sync_first_len     <= SYNC_FIRST_RST;
            cfg_reg.sync_second_len    <= SYNC_SECOND_RST;
            cfg_reg.zero_half_len      <= ZERO_HALF_RST;
            cfg_reg.one_half_len       <= ONE_HALF_RST;
            cfg_reg.header_pilot_count <= HDR_PILOT_RST;
            cfg_reg.data_pilot_count   <= DATA_PILOT_RST;
            cfg_reg.pause_len          <= PAUSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/tbpg_engine.sv -----
// ---------------------------------------------------------------------------
// Tape block pulse generator engine
// Playback state and the state update for one command transaction.
// ---------------------------------------------------------------------------
module tbpg_engine
    import tbpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    play_e_t               play_reg,        play_next;
    phase_e_t              phase_reg,       phase_next;
    logic [CYCLE_BITS-1:0] edge_start_reg,  edge_start_next;
    logic [COUNT_BITS-1:0] pilot_done_reg,  pilot_done_next;
    logic [COUNT_BITS-1:0] pilot_target_reg, pilot_target_next;
    logic                  level_reg,       level_next;
    logic [7:0]            bit_select_reg,  bit_select_next;
    logic                  second_half_reg, second_half_next;
    logic [LEN_BITS-1:0]   bit_half_reg,    bit_half_next;
    logic [OFFS_BITS-1:0]  offset_reg,      offset_next;
    logic [OFFS_BITS-1:0]  size_reg,        size_next;
    logic                  final_reg,       final_next;
    logic                  request_reg,     request_next;
    logic                  ended;

    logic [CYCLE_BITS-1:0] elapsed;
    logic                  start_req;
    logic [7:0]            bit_rot;
    logic [OFFS_BITS-1:0]  offset_inc;

    assign elapsed    = item.cycle_now - edge_start_reg;
    assign bit_rot    = {bit_select_reg[0], bit_select_reg[7:1]};
    assign offset_inc = offset_reg + OFFS_BITS'(1);
    assign start_req  = step_en && ((cmd_e_t'(item.cmd) == CMD_START) ||
                        ((cmd_e_t'(item.cmd) == CMD_TOGGLE) && (play_reg == PLAY_STOPPED)));

    // Next state for one transaction
    always_comb
    begin
        play_next         = play_reg;
        phase_next        = phase_reg;
        edge_start_next   = edge_start_reg;
        pilot_done_next   = pilot_done_reg;
        pilot_target_next = pilot_target_reg;
        level_next        = level_reg;
        bit_select_next   = bit_select_reg;
        second_half_next  = second_half_reg;
        bit_half_next     = bit_half_reg;
        offset_next       = offset_reg;
        size_next         = size_reg;
        final_next        = final_reg;
        request_next      = request_reg;
        ended             = 1'b0;

        if (start_req)
        begin
            // Load a new block and rewind pilot, bit and byte state
            size_next         = item.block_size;
            final_next        = item.last_block;
            pilot_target_next = item.block_is_data ? cfg.data_pilot_count
                                                   : cfg.header_pilot_count;
            phase_next        = PH_PILOT;
            pilot_done_next   = '0;
            level_next        = 1'b0;
            bit_select_next   = BIT_SEL_MSB;
            second_half_next  = 1'b0;
            bit_half_next     = cfg.zero_half_len;
            offset_next       = '0;
            request_next      = 1'b0;
            edge_start_next   = item.cycle_now;
            if (play_reg == PLAY_STOPPED)
            begin
                play_next = PLAY_RUNNING;
            end
        end
        else if (step_en)
        begin
            unique case (cmd_e_t'(item.cmd))
                CMD_TOGGLE:
                begin
                    // Stopped case is handled as a start above
                    play_next = (play_reg == PLAY_RUNNING) ? PLAY_PAUSED : PLAY_RUNNING;
                end
                CMD_STOP:
                begin
                    play_next    = PLAY_STOPPED;
                    phase_next   = PH_PILOT;
                    offset_next  = '0;
                    request_next = 1'b0;
                    final_next   = 1'b0;
                end
                default:
                begin
                    if (play_reg == PLAY_RUNNING)
                    begin
                        if (phase_reg == PH_PAUSE)
                        begin
                            // Raise the block request once the pause has run out
                            if (!request_reg &&
                                (elapsed > {{(CYCLE_BITS-PAUSE_BITS){1'b0}}, cfg.pause_len}))
                            begin
                                request_next = 1'b1;
                            end
                        end
                        else if (elapsed > GAP_LIMIT_CYC)
                        begin
                            // Long gap: resync the edge time, no toggle
                            edge_start_next = item.cycle_now;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_PILOT:
                                begin
                                    if (elapsed > CYCLE_BITS'(cfg.pilot_half_len))
                                    begin
                                        edge_start_next = item.cycle_now;
                                        level_next      = !level_reg;
                                        if (pilot_done_reg >= pilot_target_reg)
                                        begin
                                            pilot_done_next = '0;
                                            phase_next      = PH_SYNC1;
                                        end
                                        else
                                        begin
                                            pilot_done_next = pilot_done_reg + COUNT_BITS'(1);
                                        end
                                    end
                                end
                                PH_SYNC1:
                                begin
                                    if (elapsed > CYCLE_BITS'(cfg.sync_first_len))
                                    begin
                                        edge_start_next = item.cycle_now;
                                        level_next      = !level_reg;
                                        phase_next      = PH_SYNC2;
                                    end
                                end
                                PH_SYNC2:
                                begin
                                    if (elapsed > CYCLE_BITS'(cfg.sync_second_len))
                                    begin
                                        edge_start_next = item.cycle_now;
                                        level_next      = !level_reg;
                                        bit_half_next   = |(item.cur_byte & bit_select_reg)
                                                          ? cfg.one_half_len
                                                          : cfg.zero_half_len;
                                        phase_next      = PH_DATA;
                                    end
                                end
                                default:
                                begin
                                    if (elapsed > CYCLE_BITS'(bit_half_reg))
                                    begin
                                        edge_start_next = item.cycle_now;
                                        level_next      = !level_reg;
                                        if (!second_half_reg)
                                        begin
                                            second_half_next = 1'b1;
                                        end
                                        else
                                        begin
                                            // Bit done: advance to the next bit or byte
                                            second_half_next = 1'b0;
                                            bit_select_next  = bit_rot;
                                            if (bit_rot == BIT_SEL_MSB)
                                            begin
                                                offset_next = offset_inc;
                                                if (offset_inc == size_reg)
                                                begin
                                                    phase_next = PH_PAUSE;
                                                    level_next = 1'b0;
                                                    if (final_reg)
                                                    begin
                                                        play_next    = PLAY_STOPPED;
                                                        phase_next   = PH_PILOT;
                                                        offset_next  = '0;
                                                        request_next = 1'b0;
                                                        final_next   = 1'b0;
                                                        ended        = 1'b1;
                                                    end
                                                end
                                                else
                                                begin
                                                    bit_half_next = item.next_byte[7]
                                                                    ? cfg.one_half_len
                                                                    : cfg.zero_half_len;
                                                end
                                            end
                                            else
                                            begin
                                                bit_half_next = |(item.cur_byte & bit_rot)
                                                                ? cfg.one_half_len
                                                                : cfg.zero_half_len;
                                            end
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    // Result fields from the updated state
    always_comb
    begin
        result.ear_level     = (play_next == PLAY_RUNNING) && (phase_next != PH_PAUSE)
                               && level_next;
        result.play_status   = play_next;
        result.signal_phase  = phase_next;
        result.byte_offset   = offset_next;
        result.block_request = request_next;
        result.tape_end      = ended;
    end

    // Hold the playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg         <= PLAY_STOPPED;
            phase_reg        <= PH_PILOT;
            edge_start_reg   <= '0;
            pilot_done_reg   <= '0;
            pilot_target_reg <= HDR_PILOT_RST;
            level_reg        <= 1'b0;
            bit_select_reg   <= BIT_SEL_MSB;
            second_half_reg  <= 1'b0;
            bit_half_reg     <= ZERO_HALF_RST;
            offset_reg       <= '0;
            size_reg         <= '0;
            final_reg        <= 1'b0;
            request_reg      <= 1'b0;
        end
        else
        begin
            play_reg         <= play_next;
            phase_reg        <= phase_next;
            edge_start_reg   <= edge_start_next;
            pilot_done_reg   <= pilot_done_next;
            pilot_target_reg <= pilot_target_next;
            level_reg        <= level_next;
            bit_select_reg   <= bit_select_next;
            second_half_reg  <= second_half_next;
            bit_half_reg     <= bit_half_next;
            offset_reg       <= offset_next;
            size_reg         <= size_next;
            final_reg        <= final_next;
            request_reg      <= request_next;
        end
    end

endmodule

// ----- hw/rtl/tape_block_pulse_generator.sv -----
// A command transaction is held in the input register, then the update logic feeds
// the result register; a full result slot that is not draining stalls the step.
// Throughput: one transaction per cycle while result_ready keeps the result slot free.
// Reset (rst_n low, asynchronous): playback stopped, pilot phase, level low,
// timing registers at their defaults, input and result registers empty.
// ---------------------------------------------------------------------------
// Tape block pulse generator, top level
// Turns tape blocks into the cassette ear level from the processor cycle count.
// ---------------------------------------------------------------------------
`include "tape_block_pulse_generator_assert.svh"

module tape_block_pulse_generator
    import tbpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  in_item_t                 item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output out_item_t                result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_full_reg, item_full_next;
    out_item_t res_reg;
    out_item_t step_result;
    logic      res_valid_reg, res_valid_next;
    logic      step_en;
    logic      item_take;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    tbpg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance when an item waits and the result slot is free or draining
    assign step_en    = item_full_reg && (!res_valid_reg || result_ready);
    assign item_ready = !item_full_reg || step_en;
    assign item_take  = item_valid && item_ready;

    tbpg_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Occupancy of the input and result registers
    always_comb
    begin
        item_full_next = item_take ? 1'b1 : (step_en ? 1'b0 : item_full_reg);
        res_valid_next = step_en ? 1'b1 : ((result_ready) ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            item_full_reg <= item_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (step_en)
        begin
            res_reg <= step_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Tape end reports a rewound, silent tape
    `TBPG_ASSERT_SAME(a_tape_end_rewound, result_valid && result.tape_end, (result.play_status == PLAY_STOPPED) && (result.signal_phase == PH_PILOT) && (result.byte_offset == '0) && !result.ear_level, "tape end without rewind")
    // Level stays low unless playing outside the pause
    `TBPG_ASSERT_SAME(a_level_quiet, result_valid && ((result.play_status != PLAY_RUNNING) || (result.signal_phase == PH_PAUSE)), !result.ear_level, "ear level high while silent")
    // An accepted transaction leaves the input register occupied
    `TBPG_ASSERT_NEXT(a_item_held, item_valid && item_ready, item_full_reg, "accepted transaction lost")
    // A completed step always produces a result
    `TBPG_ASSERT_NEXT(a_step_result, step_en, result_valid, "step without result")

endmodule
